### design/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AHS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/ahs_pkg.sv
// Package with the types, codes and constants of the address hash set.
package ahs_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int ADDR_BITS_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 64;
  localparam int COUNT_W = 11;
  localparam int TBITS_W = 6;
  localparam int TSIZE_W = 33;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd1;

  localparam logic [TBITS_W-1:0] BITS_MIN = 6'd4;
  localparam logic [TBITS_W-1:0] BITS_MAX = 6'd32;

  typedef struct packed {
    logic start;
    logic scan;
    logic ins;
    logic refuse;
    logic mv_rd;
    logic mv_wr;
    logic load;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic present;
    logic is_add;
    logic is_del;
    logic full;
    logic out_busy;
  } stat_t;

endpackage

### design/ahs_req_if.sv
// Request channel interface: command and address.
interface ahs_req_if;
  import ahs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink (input valid, input cmd, input address, output ready);
endinterface

### design/ahs_rsp_if.sv
// Response channel interface: presence, count, index width and error flag.
interface ahs_rsp_if;
  import ahs_pkg::*;
  logic               valid;
  logic               ready;
  logic               was_present;
  logic [COUNT_W-1:0] entry_count;
  logic [TBITS_W-1:0] table_bits;
  logic               full_error;

  modport source (output valid, output was_present, output entry_count,
                  output table_bits, output full_error, input ready);
  modport sink (input valid, input was_present, input entry_count,
                input table_bits, input full_error, output ready);
endinterface

### design/ahs_ram.sv
// Generic single-port RAM with registered read.
module ahs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/ahs_ctrl.sv
// Controller state machine that sequences lookup, update and response.
module ahs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ahs_pkg::stat_t stat,
  output ahs_pkg::ctrl_t ctrl
);
  import ahs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctrl.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.hit || stat.scan_end) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        priority if (stat.is_add && !stat.present) begin
          if (stat.full) begin
            ctrl.refuse = 1'b1;
          end else begin
            ctrl.ins = 1'b1;
          end
          state_next = S_FIN;
        end else if (stat.is_del && stat.present) begin
          ctrl.mv_rd = 1'b1;
          state_next = S_MOVE;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MOVE: begin
        ctrl.mv_wr = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          ctrl.load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/ahs_dp.sv
// Datapath: key store, scan pointer, count, index width and response register.
module ahs_dp #(
  parameter int CAPACITY  = ahs_pkg::CAPACITY_DEF,
  parameter int ADDR_BITS = ahs_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ahs_pkg::ctrl_t              ctrl,
  output ahs_pkg::stat_t              stat,
  input  logic [ahs_pkg::CMD_W-1:0]   in_cmd,
  input  logic [ahs_pkg::ADDR_W-1:0]  in_address,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_was_present,
  output logic [ahs_pkg::COUNT_W-1:0] out_entry_count,
  output logic [ahs_pkg::TBITS_W-1:0] out_table_bits,
  output logic                        out_full_error
);
  import ahs_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     cnt_dec;
  logic [CNT_W-1:0]     ptr;
  logic [TBITS_W-1:0]   bits;
  logic [TBITS_W-1:0]   bits_up;
  logic [TBITS_W-1:0]   bits_dn;
  logic [TSIZE_W-1:0]   tsize;
  logic                 grow;
  logic                 shrink;
  logic [CMD_W-1:0]     op;
  logic [ADDR_BITS-1:0] key;
  logic                 present;
  logic                 refused;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic [IDX_W-1:0]     slot;
  logic                 hit;
  logic                 issue;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [ADDR_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0] ram_rdata;

  ahs_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Held keys always occupy slots 0 to count-1, so the count serves as the
  // valid marks.  A delete moves the last held key into the freed slot.
  assign cnt_dec = count - CNT_W'(1);
  assign hit     = cmp_vld && (ram_rdata == key);
  assign issue   = ctrl.scan && (ptr < count) && !hit;

  assign tsize   = TSIZE_W'(1) << bits;
  assign grow    = TSIZE_W'(count) > tsize;
  assign shrink  = TSIZE_W'(cnt_dec) < (tsize >> 2);
  assign bits_up = (bits >= BITS_MAX) ? BITS_MAX : bits + TBITS_W'(1);
  assign bits_dn = (bits <= BITS_MIN) ? BITS_MIN : bits - TBITS_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = key;
    ram_addr  = ptr[IDX_W-1:0];
    priority if (ctrl.mv_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
      ram_addr  = slot;
    end else if (ctrl.ins) begin
      ram_we    = 1'b1;
      ram_addr  = count[IDX_W-1:0];
    end else if (ctrl.mv_rd) begin
      ram_addr  = cnt_dec[IDX_W-1:0];
    end
  end

  always_comb begin
    stat.hit      = hit;
    stat.scan_end = (ptr >= count) && !cmp_vld;
    stat.present  = present;
    stat.is_add   = (op == CMD_ADD);
    stat.is_del   = (op == CMD_DEL);
    stat.full     = (count == CNT_W'(CAPACITY));
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bits      <= BITS_MIN;
      ptr       <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (ctrl.start) begin
        ptr <= '0;
      end else if (issue) begin
        ptr <= ptr + CNT_W'(1);
      end
      if (ctrl.ins) begin
        count <= count + CNT_W'(1);
        if (grow) begin
          bits <= bits_up;
        end
      end else if (ctrl.mv_wr) begin
        count <= cnt_dec;
        if (shrink) begin
          bits <= bits_dn;
        end
      end
      if (ctrl.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op      <= in_cmd;
      key     <= in_address[ADDR_BITS-1:0];
      present <= 1'b0;
      refused <= 1'b0;
    end else begin
      if (ctrl.scan && hit) begin
        present <= 1'b1;
        slot    <= cmp_idx;
      end
      if (ctrl.refuse) begin
        refused <= 1'b1;
      end
    end
    if (issue) begin
      cmp_idx <= ptr[IDX_W-1:0];
    end
    if (ctrl.load) begin
      out_was_present <= present;
      out_entry_count <= COUNT_W'(count);
      out_table_bits  <= bits;
      out_full_error  <= refused;
    end
  end

endmodule

### design/address_hash_set.sv
// Top level of the address hash set: controller, datapath and channel wiring.
//
//   channel  dir  payload                                             
//   req      in   cmd, address                                        
//   rsp      out  was_present, entry_count, table_bits, full_error    
//
// An item passes an accept step, a scan in which the single registered key RAM
// read port walks the store, an update step and a response load; a delete that
// hits takes one more step for the move.
// Reset empties the set at once and sets the index width to four.
// A stalled response holds in its register; the next request is taken
// meanwhile and waits at the response stage until the register frees.
`include "assert_macros.svh"

module address_hash_set #(
  parameter int CAPACITY  = ahs_pkg::CAPACITY_DEF,
  parameter int ADDR_BITS = ahs_pkg::ADDR_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ahs_req_if.sink  req,
  ahs_rsp_if.source rsp
);
  import ahs_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ahs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ahs_dp #(
    .CAPACITY  (CAPACITY),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (req.cmd),
    .in_address      (req.address),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .out_was_present (rsp.was_present),
    .out_entry_count (rsp.entry_count),
    .out_table_bits  (rsp.table_bits),
    .out_full_error  (rsp.full_error)
  );

  `AHS_ASSERT_NEXT(a_start_scans, clk, rst, req.valid && req.ready, ctrl.scan)
  `AHS_ASSERT_NOW(a_no_insert_full, clk, rst, ctrl.ins, !stat.full)
  `AHS_ASSERT_NOW(a_refused_absent, clk, rst, rsp.valid && rsp.full_error, !rsp.was_present)
  `AHS_ASSERT_NOW(a_bits_range, clk, rst, rsp.valid, (rsp.table_bits >= BITS_MIN) && (rsp.table_bits <= BITS_MAX))

endmodule

### bench/address_hash_set_tb.sv
// Self-checking testbench for the address hash set: predicts every response and compares it.
`timescale 1ns / 1ps

module address_hash_set_tb;
  import ahs_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int KEY_POOL_SIZE = 96;
  localparam int SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 80;
  localparam int MAX_REPORTS = 40;
  localparam longint CYCLE_LIMIT = 64'd8_000_000;

  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [ADDR_W-1:0] KEY_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS_DEF);

  typedef struct packed {
    logic               was_present;
    logic [COUNT_W-1:0] entry_count;
    logic [TBITS_W-1:0] table_bits;
    logic               full_error;
  } set_rsp_t;

  class set_scoreboard;
    logic [ADDR_W-1:0] slot_key [CAPACITY];
    bit                slot_used [CAPACITY];
    int unsigned       held;
    int unsigned       bits;
    set_rsp_t          pending_rsp[$];
    int unsigned       errors;
    int unsigned       reports;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      held = 0;
      bits = BITS_MIN;
      errors = 0;
      reports = 0;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] address);
      int hit;
      int open;
      logic [ADDR_W-1:0] key;
      set_rsp_t r;
      key = address & KEY_MASK;
      hit = -1;
      open = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
        if (!slot_used[i] && open < 0) open = i;
      end
      r.was_present = (hit >= 0);
      r.full_error = 1'b0;
      if (cmd == CMD_ADD && hit < 0) begin
        if (open < 0) begin
          r.full_error = 1'b1;
        end else begin
          if (64'(held) > (64'd1 << bits)) bits = (bits + 1 > BITS_MAX) ? BITS_MAX : bits + 1;
          slot_key[open] = key;
          slot_used[open] = 1'b1;
          held++;
        end
      end else if (cmd == CMD_DEL && hit >= 0) begin
        slot_used[hit] = 1'b0;
        held--;
        if (64'(held) < ((64'd1 << bits) / 4)) begin
          bits = (bits - 1 < BITS_MIN) ? BITS_MIN : bits - 1;
        end
      end
      r.entry_count = held[COUNT_W-1:0];
      r.table_bits = bits[TBITS_W-1:0];
      pending_rsp.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_response(set_rsp_t got);
      set_rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: response with none expected, expected nothing actual %h", $time, got);
        end
        return;
      end
      want = pending_rsp.pop_front();
      if (got.was_present !== want.was_present)
        report("was_present", want.was_present, got.was_present);
      if (got.entry_count !== want.entry_count)
        report("entry_count", want.entry_count, got.entry_count);
      if (got.table_bits !== want.table_bits)
        report("table_bits", want.table_bits, got.table_bits);
      if (got.full_error !== want.full_error)
        report("full_error", want.full_error, got.full_error);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 1'b0;

  set_scoreboard tracker = new();
  logic [ADDR_W-1:0] key_pool [KEY_POOL_SIZE];

  ahs_req_if req_bus();
  ahs_rsp_if rsp_bus();

  address_hash_set u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] address);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.cmd <= cmd;
    req_bus.address <= address;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    tracker.note_request(cmd, address);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_rsp.size() != 0);
  endtask

  task automatic random_item(bit growing);
    int r;
    logic [CMD_W-1:0] cmd;
    logic [ADDR_W-1:0] address;
    r = $urandom_range(0, 99);
    if (r < (growing ? 60 : 5)) cmd = CMD_ADD;
    else if (r < 85) cmd = CMD_DEL;
    else if (r < 96) cmd = CMD_CHECK;
    else cmd = CMD_UNUSED;
    if (cmd != CMD_ADD && $urandom_range(0, 9) == 0) address = {$urandom, $urandom};
    else address = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    send_req(cmd, address);
  endtask

  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int stall;
    set_rsp_t got;
    stall = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        got.was_present = rsp_bus.was_present;
        got.entry_count = rsp_bus.entry_count;
        got.table_bits = rsp_bus.table_bits;
        got.full_error = rsp_bus.full_error;
        tracker.check_response(got);
      end
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        stall--;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] last_key;
    logic [ADDR_W-1:0] spare_key;
    req_bus.valid <= 1'b0;
    req_bus.cmd <= CMD_CHECK;
    req_bus.address <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      case (i % 4)
        0: key_pool[i] = {$urandom, $urandom};
        1: key_pool[i] = {key_pool[i-1][63:40], 40'(i)};
        2: key_pool[i] = {16'(i), $urandom, 16'hFFFF};
        default: key_pool[i] = ~key_pool[i-3];
      endcase
    end

    // Directed: empty set, duplicates, the unused command and extreme keys.
    send_req(CMD_CHECK, 64'h0);
    send_req(CMD_DEL, 64'h0);
    send_req(CMD_ADD, 64'h0);
    send_req(CMD_ADD, 64'h0);
    send_req(CMD_CHECK, 64'h0);
    send_req(CMD_UNUSED, 64'h0);
    send_req(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(CMD_ADD, 64'h8000_0000_0000_0000);
    send_req(CMD_ADD, 64'h0000_0000_0000_0001);
    send_req(CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF);
    send_req(CMD_ADD, 64'h8000_0000_0000_0001);
    send_req(CMD_DEL, 64'h8000_0000_0000_0000);
    send_req(CMD_CHECK, 64'h8000_0000_0000_0001);
    send_req(CMD_CHECK, 64'h8000_0000_0000_0000);
    send_req(CMD_DEL, 64'h0);
    send_req(CMD_DEL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(CMD_DEL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(CMD_UNUSED, 64'h7FFF_FFFF_FFFF_FFFF);
    send_req(CMD_ADD, 64'hAAAA_AAAA_5555_5555);
    send_req(CMD_DEL, 64'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();

    // Alternate growing and shrinking stretches so the index width moves both ways.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      quiet = (seg % 4 == 3);
      for (int n = 0; n < SEGMENT_ITEMS; n++) random_item(seg % 2 == 0);
      if (seg == 5) wait_drained();
    end
    quiet = 1'b0;

    // Fill the store completely, then probe refused and accepted adds.
    last_key = '0;
    while (tracker.held < CAPACITY) begin
      last_key = {$urandom, 22'h2A_5A5A, 10'(tracker.held)};
      send_req(CMD_ADD, last_key);
    end
    spare_key = {$urandom, $urandom};
    send_req(CMD_ADD, spare_key);
    send_req(CMD_ADD, ~spare_key);
    send_req(CMD_ADD, last_key);
    send_req(CMD_CHECK, last_key);
    send_req(CMD_UNUSED, spare_key);
    send_req(CMD_DEL, spare_key);
    send_req(CMD_DEL, last_key);
    send_req(CMD_ADD, spare_key);
    send_req(CMD_ADD, ~spare_key);
    send_req(CMD_CHECK, spare_key);
    send_req(CMD_DEL, spare_key);
    send_req(CMD_CHECK, key_pool[0]);

    wait_drained();
    repeat (50) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
